@@ rtl/tae_pkg.sv @@
// shared types and operation codes for the thumb alu execute block
// no dependencies
`default_nettype none

package tae_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth   = 4;
  localparam int unsigned AmtWidth  = 8;

  localparam logic [OpWidth-1:0] OP_AND = 4'd0;
  localparam logic [OpWidth-1:0] OP_EOR = 4'd1;
  localparam logic [OpWidth-1:0] OP_LSL = 4'd2;
  localparam logic [OpWidth-1:0] OP_LSR = 4'd3;
  localparam logic [OpWidth-1:0] OP_ASR = 4'd4;
  localparam logic [OpWidth-1:0] OP_ADC = 4'd5;
  localparam logic [OpWidth-1:0] OP_SBC = 4'd6;
  localparam logic [OpWidth-1:0] OP_ROR = 4'd7;
  localparam logic [OpWidth-1:0] OP_TST = 4'd8;
  localparam logic [OpWidth-1:0] OP_NEG = 4'd9;
  localparam logic [OpWidth-1:0] OP_CMP = 4'd10;
  localparam logic [OpWidth-1:0] OP_CMN = 4'd11;
  localparam logic [OpWidth-1:0] OP_ORR = 4'd12;
  localparam logic [OpWidth-1:0] OP_MUL = 4'd13;
  localparam logic [OpWidth-1:0] OP_BIC = 4'd14;
  localparam logic [OpWidth-1:0] OP_MVN = 4'd15;

  typedef struct packed {
    logic [OpWidth-1:0]   operation;
    logic [DataWidth-1:0] operand_a;
    logic [DataWidth-1:0] operand_b;
    logic                 carry_in;
    logic                 ovf_in;
  } item_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 write_dest;
    logic                 neg_out;
    logic                 zero_out;
    logic                 carry_out;
    logic                 ovf_out;
  } res_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 carry;
  } shift_res_t;

endpackage

`default_nettype wire

@@ rtl/tae_shifter.sv @@
// barrel shifter for lsl, lsr, asr and ror with arm carry rules
// depends on tae_pkg
`default_nettype none

module tae_shifter (
  input  wire logic [tae_pkg::OpWidth-1:0]   operation,
  input  wire logic [tae_pkg::DataWidth-1:0] operand_a,
  input  wire logic [tae_pkg::AmtWidth-1:0]  amount,
  input  wire logic                          carry_in,
  output tae_pkg::shift_res_t                shift_res
);
  import tae_pkg::*;

  logic [4:0]           rot;
  logic                 amt_zero;
  logic                 amt_big;     // 32 or more
  logic                 amt_32;
  logic [DataWidth:0]   lsl_ext;
  logic [DataWidth:0]   lsr_ext;
  logic [DataWidth:0]   asr_ext;
  logic [2*DataWidth-1:0] ror_ext;
  logic [DataWidth-1:0] ror_val;

  assign rot      = amount[4:0];
  assign amt_zero = (amount == '0);
  assign amt_big  = (amount[7:5] != 3'd0);
  assign amt_32   = (amount[7:5] == 3'd1) && (rot == 5'd0);

  // extra bit catches the last bit shifted out
  assign lsl_ext = {1'b0, operand_a} << rot;
  assign lsr_ext = {operand_a, 1'b0} >> rot;
  assign asr_ext = $signed({operand_a, 1'b0}) >>> rot;
  assign ror_ext = {operand_a, operand_a} >> rot;
  assign ror_val = ror_ext[DataWidth-1:0];

  always_comb begin
    shift_res.result = operand_a;
    shift_res.carry  = carry_in;
    if (!amt_zero) begin
      unique case (operation)
        OP_LSL: begin
          if (amt_32) begin
            shift_res.result = '0;
            shift_res.carry  = operand_a[0];
          end else if (amt_big) begin
            shift_res.result = '0;
            shift_res.carry  = 1'b0;
          end else begin
            shift_res.result = lsl_ext[DataWidth-1:0];
            shift_res.carry  = lsl_ext[DataWidth];
          end
        end
        OP_LSR: begin
          if (amt_32) begin
            shift_res.result = '0;
            shift_res.carry  = operand_a[DataWidth-1];
          end else if (amt_big) begin
            shift_res.result = '0;
            shift_res.carry  = 1'b0;
          end else begin
            shift_res.result = lsr_ext[DataWidth:1];
            shift_res.carry  = lsr_ext[0];
          end
        end
        OP_ASR: begin
          if (amt_big) begin
            shift_res.result = {DataWidth{operand_a[DataWidth-1]}};
            shift_res.carry  = operand_a[DataWidth-1];
          end else begin
            shift_res.result = asr_ext[DataWidth:1];
            shift_res.carry  = asr_ext[0];
          end
        end
        OP_ROR: begin
          // rotate by a multiple of 32 leaves the value, carry is bit 31
          shift_res.result = ror_val;
          shift_res.carry  = ror_val[DataWidth-1];
        end
        default: begin
          shift_res.result = operand_a;
          shift_res.carry  = carry_in;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/tae_alu.sv @@
// combinational thumb alu: logic, add/subtract, multiply, shifts and flags
// depends on tae_pkg and tae_shifter
`default_nettype none

module tae_alu (
  input  tae_pkg::item_t item,
  output tae_pkg::res_t  res
);
  import tae_pkg::*;

  shift_res_t           shift_res;
  logic [DataWidth-1:0] add_x;
  logic [DataWidth-1:0] add_y;
  logic                 add_cin;
  logic [DataWidth:0]   sum;
  logic [DataWidth-1:0] add_r;
  logic                 add_v;
  logic [DataWidth-1:0] product;
  logic [DataWidth-1:0] a;
  logic [DataWidth-1:0] b;
  logic [DataWidth-1:0] r;
  logic                 c;
  logic                 v;

  assign a = item.operand_a;
  assign b = item.operand_b;

  tae_shifter u_shifter (
    .operation (item.operation),
    .operand_a (a),
    .amount    (b[AmtWidth-1:0]),
    .carry_in  (item.carry_in),
    .shift_res (shift_res)
  );

  // shared adder for adc, sbc, neg, cmp, cmn
  always_comb begin
    add_x   = a;
    add_y   = b;
    add_cin = item.carry_in;
    case (item.operation)
      OP_SBC: add_y = ~b;
      OP_NEG: begin
        add_x   = '0;
        add_y   = ~b;
        add_cin = 1'b1;
      end
      OP_CMP: begin
        add_y   = ~b;
        add_cin = 1'b1;
      end
      OP_CMN: add_cin = 1'b0;
      default: ;
    endcase
  end

  assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{DataWidth{1'b0}}, add_cin};
  assign add_r = sum[DataWidth-1:0];
  assign add_v = ~(add_x[DataWidth-1] ^ add_y[DataWidth-1])
               & (add_x[DataWidth-1] ^ add_r[DataWidth-1]);

  assign product = a * b;

  always_comb begin
    r = '0;
    c = item.carry_in;
    v = item.ovf_in;
    unique case (item.operation) inside
      OP_AND, OP_TST: r = a & b;
      OP_EOR:         r = a ^ b;
      OP_ORR:         r = a | b;
      OP_BIC:         r = a & ~b;
      OP_MVN:         r = ~b;
      OP_MUL:         r = product;
      OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
        r = shift_res.result;
        c = shift_res.carry;
      end
      OP_ADC, OP_SBC, OP_NEG, OP_CMP, OP_CMN: begin
        r = add_r;
        c = sum[DataWidth];
        v = add_v;
      end
      default: r = '0;
    endcase
  end

  always_comb begin
    res.result    = r;
    res.neg_out   = r[DataWidth-1];
    res.zero_out  = (r == '0);
    res.carry_out = c;
    res.ovf_out   = v;
    unique case (item.operation) inside
      OP_TST, OP_CMP, OP_CMN: res.write_dest = 1'b0;
      default:                res.write_dest = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/thumb_alu_execute.sv @@
// top level of the thumb alu execute block: input register, alu, result register
// depends on tae_pkg and tae_alu
//
//   channel | valid     | ready     | payload
//   op      | op_valid  | op_ready  | operation, operand_a, operand_b, flags in
//   res     | res_valid | res_ready | result, write_dest, flags out
//
// one item per cycle sustained while the result side does not stall; an item moves from
// the input register through the alu with its 32x32 multiplier to the result register.
// reset empties both registers. a stall on the result side holds the result register
// and a full input register, which refills as soon as the result register moves.
`default_nettype none

module thumb_alu_execute (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          op_valid,
  output logic                               op_ready,
  input  wire logic [tae_pkg::OpWidth-1:0]   operation,
  input  wire logic [tae_pkg::DataWidth-1:0] operand_a,
  input  wire logic [tae_pkg::DataWidth-1:0] operand_b,
  input  wire logic                          neg_in,
  input  wire logic                          zero_in,
  input  wire logic                          carry_in,
  input  wire logic                          ovf_in,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic [tae_pkg::DataWidth-1:0]      result,
  output logic                               write_dest,
  output logic                               neg_out,
  output logic                               zero_out,
  output logic                               carry_out,
  output logic                               ovf_out
);
  import tae_pkg::*;

  item_t item;
  logic  item_valid;
  res_t  alu_res;
  res_t  res;
  logic  adv_res;
  logic  adv_item;
  logic  unused_flags;

  // incoming n and z are always recomputed
  assign unused_flags = neg_in ^ zero_in;

  assign adv_res  = !res_valid || res_ready;
  assign adv_item = !item_valid || adv_res;
  assign op_ready = adv_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (adv_item) begin
      item_valid <= op_valid;
    end
    if (adv_item && op_valid) begin
      item.operation <= operation;
      item.operand_a <= operand_a;
      item.operand_b <= operand_b;
      item.carry_in  <= carry_in;
      item.ovf_in    <= ovf_in;
    end
  end

  tae_alu u_alu (
    .item (item),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv_res) begin
      res_valid <= item_valid;
    end
    if (adv_res && item_valid) begin
      res <= alu_res;
    end
  end

  assign result     = res.result;
  assign write_dest = res.write_dest & ~(unused_flags & 1'b0);
  assign neg_out    = res.neg_out;
  assign zero_out   = res.zero_out;
  assign carry_out  = res.carry_out;
  assign ovf_out    = res.ovf_out;

endmodule

`default_nettype wire

@@ rtl/tae_checker.sv @@
// port-level checks for thumb_alu_execute, attached by bind
// depends on the top level's ports only
`default_nettype none

module tae_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        op_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] result,
  input wire logic        neg_out,
  input wire logic        zero_out,
  input wire logic        carry_out,
  input wire logic        ovf_out,
  input wire logic        write_dest
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // an empty result register never blocks the input
  a_accept_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> op_ready)
    else $error("input stalled with empty result stage");

  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (neg_out == result[31]) && (zero_out == (result == 32'd0)))
    else $error("n or z flag inconsistent with result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(result) && $stable(carry_out)
      && $stable(ovf_out) && $stable(write_dest))
    else $error("stalled result item changed");

endmodule

bind thumb_alu_execute tae_checker u_tae_checker (
  .clk        (clk),
  .rst        (rst),
  .op_ready   (op_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .result     (result),
  .neg_out    (neg_out),
  .zero_out   (zero_out),
  .carry_out  (carry_out),
  .ovf_out    (ovf_out),
  .write_dest (write_dest)
);

`default_nettype wire
